>>> rtl/ucs_pkg.sv
// Package: payload types and fixed constants for the child selector.
`default_nettype none
package ucs_pkg;
    localparam int VALUE_W = 16;
    localparam int VISIT_W = 20;
    localparam int PRIOR_W = 16;
    localparam int INDEX_W = 7;
    localparam int TOTAL_W = 27;
    localparam int WEIGHT_W = 16;
    localparam int LNQ_W = 22;
    localparam int RATIO_W = 38;
    localparam int ROOT_W = 27;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd1638;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_estimate;
        logic [VISIT_W-1:0] visit_count;
        logic [PRIOR_W-1:0] prior_prob;
        logic last_entry;
    } ucs_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] best_ucb_index;
        logic best_ucb_valid;
        logic [INDEX_W-1:0] best_new_index;
        logic best_new_valid;
    } ucs_out_t;
endpackage
`default_nettype wire

>>> rtl/ucs_ln.sv
// Iterative fixed-point natural log of (visit total + 2), one squaring per cycle.
`default_nettype none
module ucs_ln (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic [ucs_pkg::TOTAL_W-1:0] total,
    output logic done,
    output logic [ucs_pkg::LNQ_W-1:0] lnq
);
    import ucs_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_NORM = 3'd1, S_SQ = 3'd2, S_MUL = 3'd3,
                           S_DONE = 3'd4;
    logic [2:0] st_reg, st_next;
    logic [TOTAL_W:0] x_reg;
    logic [TOTAL_W:0] xo_reg;
    logic [4:0] e_reg;
    logic [31:0] m_reg;
    logic [15:0] frac_reg;
    logic [4:0] cnt_reg;
    logic [63:0] sq;
    logic [20:0] l2;
    logic [37:0] prod;
    logic [LNQ_W-1:0] lnq_reg;

    assign sq = {32'd0, m_reg} * {32'd0, m_reg};
    assign l2 = {e_reg, frac_reg};
    assign prod = {17'd0, l2} * {22'd0, LN2_Q16} + 38'd32768;
    assign done = (st_reg == S_DONE);
    assign lnq = lnq_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (start) st_next = S_NORM;
            S_NORM: if (x_reg[TOTAL_W:1] == '0) st_next = S_SQ;
            S_SQ:   if (cnt_reg == 5'd15) st_next = S_MUL;
            S_MUL:  st_next = S_DONE;
            S_DONE: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
        case (st_reg)
            S_IDLE: begin
                x_reg <= {1'b0, total} + 28'd2;
                xo_reg <= {1'b0, total} + 28'd2;
                e_reg <= '0;
                m_reg <= 32'd0;
                cnt_reg <= '0;
                frac_reg <= '0;
            end
            S_NORM: begin
                if (x_reg[TOTAL_W:1] != '0) begin
                    x_reg <= x_reg >> 1;
                    e_reg <= e_reg + 5'd1;
                end else begin
                    m_reg <= {4'd0, xo_reg} << (5'd30 - e_reg);
                end
            end
            S_SQ: begin
                cnt_reg <= cnt_reg + 5'd1;
                if (sq[61]) begin
                    m_reg <= sq[62:31];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end else begin
                    m_reg <= sq[61:30];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            S_MUL: lnq_reg <= prod[16 +: LNQ_W];
            default: ;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/ucs_score.sv
// Per-child score: restoring divide, bit-pair square root, weight multiply, value add.
`default_nettype none
module ucs_score (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic [ucs_pkg::LNQ_W-1:0] lnq,
    input  wire logic [ucs_pkg::VISIT_W-1:0] visits,
    input  wire logic signed [ucs_pkg::VALUE_W-1:0] value,
    input  wire logic [ucs_pkg::WEIGHT_W-1:0] weight,
    output logic done,
    output logic signed [31:0] score
);
    import ucs_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_SQRT = 3'd2, S_MUL = 3'd3,
                           S_ADD = 3'd4, S_DONE = 3'd5;
    localparam int RAD_W = RATIO_W + 16;
    logic [2:0] st_reg, st_next;
    logic [5:0] cnt_reg;
    logic [RATIO_W-1:0] q_reg;
    logic [VISIT_W:0] rem_reg, den_reg;
    logic [VISIT_W+1:0] rem_sh;
    logic [RAD_W-1:0] rad_reg;
    logic [ROOT_W+1:0] root_reg;
    logic [ROOT_W+2:0] srem_reg, srem_sh, trial;
    logic [WEIGHT_W+ROOT_W-1:0] t_reg;
    logic signed [31:0] score_reg;

    assign rem_sh = {rem_reg, q_reg[RATIO_W-1]};
    assign srem_sh = {srem_reg[ROOT_W:0], rad_reg[RAD_W-1 -: 2]};
    assign trial = {root_reg[ROOT_W:0], 2'b01};
    assign done = (st_reg == S_DONE);
    assign score = score_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE: if (start) st_next = S_DIV;
            S_DIV:  if (cnt_reg == 6'(RATIO_W - 1)) st_next = S_SQRT;
            S_SQRT: if (cnt_reg == 6'(RAD_W / 2 - 1)) st_next = S_MUL;
            S_MUL:  st_next = S_ADD;
            S_ADD:  st_next = S_DONE;
            S_DONE: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
        case (st_reg)
            S_IDLE: begin
                q_reg <= {lnq, 16'd0};
                rem_reg <= '0;
                den_reg <= {1'b0, visits} + 21'd1;
                cnt_reg <= '0;
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_reg <= (VISIT_W+1)'(rem_sh - {1'b0, den_reg});
                    q_reg <= {q_reg[RATIO_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[VISIT_W:0];
                    q_reg <= {q_reg[RATIO_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'(RATIO_W - 1)) begin
                    cnt_reg <= '0;
                    root_reg <= '0;
                    srem_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            S_SQRT: begin
                cnt_reg <= cnt_reg + 6'd1;
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                if (srem_sh >= trial) begin
                    srem_reg <= srem_sh - trial;
                    root_reg <= {root_reg[ROOT_W:0], 1'b1};
                end else begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[ROOT_W:0], 1'b0};
                end
            end
            S_MUL: t_reg <= {{ROOT_W{1'b0}}, weight} * {{WEIGHT_W{1'b0}}, root_reg[ROOT_W-1:0]};
            S_ADD: score_reg <= 32'(value) + 32'(t_reg[WEIGHT_W+ROOT_W-1:16]);
            default: ;
        endcase
        if (st_reg == S_DIV && cnt_reg == 6'(RATIO_W - 1)) begin
            rad_reg <= {q_reg[RATIO_W-2:0], (rem_sh >= {1'b0, den_reg}), 16'd0};
        end
    end
endmodule
`default_nettype wire

>>> rtl/uct_child_selector.sv
// Top level: child store memory, load counter and scan sequencer.
// Channel  | ports            | payload
// s_       | s_valid/s_ready  | ucs_in_t
// m_       | m_valid/m_ready  | ucs_out_t
// cfg_     | cfg_valid/ready  | explore weight
// Non-final children load one per cycle. After the final one the log unit normalizes,
// by the size of the visit total, and squares; then each stored child passes in turn
// through the shared divide/root unit, and the result is registered.
// No clearing pass after reset. Input and configuration stall during the log, the scan
// and the result stage; a waiting result holds the next node in its result stage only.
`default_nettype none
module uct_child_selector #(
    parameter int MAX_CHILDREN = 128
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic s_ready,
    input  wire ucs_pkg::ucs_in_t s_data,
    output logic m_valid,
    input  wire logic m_ready,
    output ucs_pkg::ucs_out_t m_data,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [ucs_pkg::WEIGHT_W-1:0] cfg_data
);
    import ucs_pkg::*;
    localparam int AW = $clog2(MAX_CHILDREN);
    localparam int CW = $clog2(MAX_CHILDREN + 1);
    localparam logic [2:0] S_LOAD = 3'd0, S_LN = 3'd1, S_RD = 3'd2, S_SC = 3'd3,
                           S_OUT = 3'd4;
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [VISIT_W-1:0] visit;
        logic [PRIOR_W-1:0] prior;
    } entry_t;

    entry_t mem [MAX_CHILDREN];
    entry_t rd_reg;
    logic [2:0] st_reg;
    logic [CW-1:0] count_reg, idx_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W:0] sum;
    logic [WEIGHT_W-1:0] weight_reg;
    logic ln_start, ln_done, sc_done;
    logic [LNQ_W-1:0] lnq;
    logic signed [31:0] score, best_score_reg;
    logic [PRIOR_W-1:0] best_prior_reg;
    logic ucb_ok_reg, new_ok_reg, out_valid_reg;
    logic [CW-1:0] ucb_idx_reg, new_idx_reg;
    logic accept, store;
    ucs_out_t out_reg;
    logic sc_go_reg;

    assign s_ready = (st_reg == S_LOAD);
    assign accept = s_valid && s_ready;
    assign store = accept && (count_reg < CW'(MAX_CHILDREN));
    assign sum = {1'b0, total_reg} + (TOTAL_W+1)'(s_data.visit_count);
    assign cfg_ready = (st_reg == S_LOAD);
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
    assign ln_start = accept && s_data.last_entry;

    ucs_ln u_ln (.aclk(aclk), .aresetn(aresetn), .start(ln_start),
        .total(store ? (sum > (TOTAL_W+1)'(TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0])
                     : total_reg),
        .done(ln_done), .lnq(lnq));

    ucs_score u_sc (.aclk(aclk), .aresetn(aresetn), .start(sc_go_reg),
        .lnq(lnq), .visits(rd_reg.visit), .value(rd_reg.value), .weight(weight_reg),
        .done(sc_done), .score(score));

    always_ff @(posedge aclk) begin
        if (store) mem[count_reg[AW-1:0]] <= '{s_data.value_estimate, s_data.visit_count,
                                                s_data.prior_prob};
        rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_LOAD;
            count_reg <= '0;
            total_reg <= '0;
            weight_reg <= WEIGHT_RESET;
            out_valid_reg <= 1'b0;
            sc_go_reg <= 1'b0;
        end else begin
            sc_go_reg <= 1'b0;
            if (cfg_valid && cfg_ready) weight_reg <= cfg_data;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (st_reg)
                S_LOAD: begin
                    if (store) begin
                        count_reg <= count_reg + CW'(1);
                        total_reg <= (sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                     : sum[TOTAL_W-1:0];
                    end
                    if (ln_start) begin
                        st_reg <= S_LN;
                        idx_reg <= '0;
                        ucb_ok_reg <= 1'b0;
                        new_ok_reg <= 1'b0;
                    end
                end
                S_LN: if (ln_done) st_reg <= (count_reg == '0) ? S_OUT : S_RD;
                S_RD: begin
                    sc_go_reg <= 1'b1;
                    st_reg <= S_SC;
                end
                S_SC: begin
                    if (sc_done) begin
                        if (!ucb_ok_reg || score > best_score_reg) begin
                            ucb_ok_reg <= 1'b1;
                            best_score_reg <= score;
                            ucb_idx_reg <= idx_reg;
                        end
                        if (rd_reg.visit == '0 &&
                            (!new_ok_reg || rd_reg.prior > best_prior_reg)) begin
                            new_ok_reg <= 1'b1;
                            best_prior_reg <= rd_reg.prior;
                            new_idx_reg <= idx_reg;
                        end
                        idx_reg <= idx_reg + CW'(1);
                        st_reg <= (idx_reg + CW'(1) == count_reg) ? S_OUT : S_RD;
                    end
                end
                S_OUT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        out_reg.best_ucb_valid <= ucb_ok_reg;
                        out_reg.best_ucb_index <= ucb_ok_reg ?
                            INDEX_W'(ucb_idx_reg) : '0;
                        out_reg.best_new_valid <= new_ok_reg;
                        out_reg.best_new_index <= new_ok_reg ?
                            INDEX_W'(new_idx_reg) : '0;
                        count_reg <= '0;
                        total_reg <= '0;
                        st_reg <= S_LOAD;
                    end
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_uct_child_selector.sv
// Testbench for uct_child_selector: predicts child picks per node and checks every result.
`timescale 1ns / 1ps
module tb_uct_child_selector;
    import ucs_pkg::*;

    localparam int NODE_DEPTH = 128;
    localparam int CYCLE_LIMIT = 2000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    ucs_in_t s_data;
    logic m_valid;
    logic m_ready;
    ucs_out_t m_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [WEIGHT_W-1:0] cfg_data;

    uct_child_selector #(.MAX_CHILDREN(NODE_DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    ucs_in_t pending_children[$];
    ucs_out_t expected_picks[$];

    logic [WEIGHT_W-1:0] weight_copy;
    logic [VALUE_W-1:0] node_values[NODE_DEPTH];
    logic [VISIT_W-1:0] node_visits[NODE_DEPTH];
    logic [PRIOR_W-1:0] node_priors[NODE_DEPTH];
    int unsigned node_children;
    logic [TOTAL_W-1:0] node_total;

    logic req_taken;
    logic calm;
    int unsigned send_gap;
    int unsigned recv_stall;
    int unsigned cycles;
    int unsigned errors;
    int unsigned picks_checked;
    int unsigned children_sent;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] ln_fixed(input logic [63:0] x);
        int unsigned e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 0;
        frac = 0;
        while (e < 40 && (x >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (((64'(e) << 16) | frac) * 64'd45426 + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] root_fixed(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic ucs_out_t rank_children();
        ucs_out_t pick;
        logic [63:0] lnq;
        logic [63:0] ratio;
        logic [63:0] root;
        longint score;
        longint best_score;
        logic [PRIOR_W-1:0] best_prior;
        pick = '0;
        best_score = 0;
        best_prior = 0;
        lnq = ln_fixed(64'(node_total) + 64'd2);
        for (int i = 0; i < node_children; i++) begin
            ratio = (lnq << 16) / (64'(node_visits[i]) + 64'd1);
            root = root_fixed(ratio << 16);
            score = longint'($signed(node_values[i]))
                  + longint'((64'(weight_copy) * root) >> 16);
            if (!pick.best_ucb_valid || score > best_score) begin
                pick.best_ucb_valid = 1'b1;
                pick.best_ucb_index = INDEX_W'(i);
                best_score = score;
            end
            if (node_visits[i] == 0 && (!pick.best_new_valid || node_priors[i] > best_prior)) begin
                pick.best_new_valid = 1'b1;
                pick.best_new_index = INDEX_W'(i);
                best_prior = node_priors[i];
            end
        end
        return pick;
    endfunction

    task automatic absorb_child(input ucs_in_t c);
        logic [TOTAL_W:0] sum;
        if (node_children < NODE_DEPTH) begin
            node_values[node_children] = c.value_estimate;
            node_visits[node_children] = c.visit_count;
            node_priors[node_children] = c.prior_prob;
            node_children++;
            sum = {1'b0, node_total} + (TOTAL_W + 1)'(c.visit_count);
            node_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
        if (c.last_entry) begin
            expected_picks.push_back(rank_children());
            node_children = 0;
            node_total = '0;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // monitor and predictor
    always @(posedge aclk) begin
        req_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            cycles <= cycles + 1;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t timeout with %0d results outstanding", $time, expected_picks.size());
                $display("== FAIL ==");
                $finish;
            end
            if (cfg_valid && cfg_ready) weight_copy = cfg_data;
            if (s_valid && s_ready) begin
                absorb_child(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_picks.size() == 0) begin
                    $display("%0t unexpected result %h", $time, m_data);
                    errors <= errors + 1;
                end else begin
                    ucs_out_t want;
                    want = expected_picks.pop_front();
                    picks_checked <= picks_checked + 1;
                    if (m_data.best_ucb_index !== want.best_ucb_index
                        || m_data.best_ucb_valid !== want.best_ucb_valid
                        || m_data.best_new_index !== want.best_new_index
                        || m_data.best_new_valid !== want.best_new_valid) begin
                        $display("%0t mismatch: expected ucb %0d/%0b new %0d/%0b, got ucb %0d/%0b new %0d/%0b",
                            $time, want.best_ucb_index, want.best_ucb_valid,
                            want.best_new_index, want.best_new_valid,
                            m_data.best_ucb_index, m_data.best_ucb_valid,
                            m_data.best_new_index, m_data.best_new_valid);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // request driver and result back-pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || req_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_children.size() > 0) begin
                    s_data <= pending_children.pop_front();
                    s_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(3) == 0) recv_stall <= pick_gap();
            end
        end
    end

    function automatic logic [VISIT_W-1:0] random_visits();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return '0;
        if (r < 60) return VISIT_W'($urandom_range(20, 1));
        if (r < 70) return '1;
        if (r < 85) return VISIT_W'($urandom_range(5000));
        return VISIT_W'($urandom);
    endfunction

    task automatic queue_child(input logic [VALUE_W-1:0] v, input logic [VISIT_W-1:0] n,
                               input logic [PRIOR_W-1:0] p, input logic last);
        ucs_in_t c;
        c.value_estimate = v;
        c.visit_count = n;
        c.prior_prob = p;
        c.last_entry = last;
        pending_children.push_back(c);
        children_sent++;
    endtask

    task automatic queue_random_node(input int unsigned kids);
        for (int i = 0; i < kids; i++)
            queue_child(VALUE_W'($urandom), random_visits(), PRIOR_W'($urandom), i == kids - 1);
    endtask

    task automatic drain();
        wait (pending_children.size() == 0 && !s_valid && expected_picks.size() == 0);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        @(negedge aclk);
        cfg_data <= w;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned budget, input int unsigned big_nodes);
        int unsigned used;
        int unsigned kids;
        int unsigned r;
        used = 0;
        for (int b = 0; b < big_nodes; b++) begin
            queue_random_node($urandom_range(131, 126));
            used += 128;
        end
        while (used < budget) begin
            r = $urandom_range(99);
            kids = (r < 80) ? $urandom_range(6, 1) : $urandom_range(30, 7);
            queue_random_node(kids);
            used += kids;
            if (used % 97 < 6) calm = ~calm;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_taken = 1'b0;
        calm = 1'b0;
        send_gap = 0;
        recv_stall = 0;
        cycles = 0;
        errors = 0;
        picks_checked = 0;
        children_sent = 0;
        weight_copy = WEIGHT_RESET;
        node_children = 0;
        node_total = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: single child, extremes, ties, all visited, all unvisited
        queue_child(16'h7fff, '0, '1, 1'b1);
        queue_child(16'h8000, '1, '0, 1'b1);
        queue_child(16'h1234, 20'd3, 16'h0100, 1'b0);
        queue_child(16'h1234, 20'd3, 16'h0100, 1'b1);
        queue_child(16'h0000, '0, 16'h4000, 1'b0);
        queue_child(16'hffff, '0, 16'h4000, 1'b0);
        queue_child(16'h0001, '0, 16'hffff, 1'b1);
        queue_child(16'h8000, '1, 16'h0001, 1'b0);
        queue_child(16'h7fff, '1, 16'hfffe, 1'b0);
        queue_child(16'h0800, 20'd1, 16'haaaa, 1'b1);
        queue_child(16'h5555, 20'h55555, 16'h5555, 1'b0);
        queue_child(16'haaaa, 20'haaaaa, 16'haaaa, 1'b1);
        drain();

        write_weight('0);
        queue_child(16'h0100, '0, 16'h0010, 1'b0);
        queue_child(16'h0200, '0, 16'h0010, 1'b1);
        random_phase(300, 0);
        drain();

        write_weight('1);
        queue_child(16'h7fff, '1, '0, 1'b0);
        queue_child(16'h8000, '0, '1, 1'b1);
        random_phase(400, 1);
        drain();

        write_weight(WEIGHT_W'($urandom));
        random_phase(500, 1);
        drain();

        write_weight(WEIGHT_RESET);
        random_phase(500, 0);
        drain();

        write_weight(WEIGHT_W'($urandom_range(8192)));
        random_phase(300, 1);
        drain();

        $display("Sent %0d children over six weight settings, checked %0d node results,",
            children_sent, picks_checked);
        $display("including full and overfull nodes, ties, and saturated visit counts.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
